// ===== rtl/core/modinv_pkg.sv =====
// ----------------------------------------------------------------------------
// modinv_pkg
// Shared widths, payload types and controller/datapath command and status
// structs for the modular inverse block.
// ----------------------------------------------------------------------------
package modinv_pkg;

   localparam int DATA_W = 31;
   localparam int SHIFT_W = (DATA_W > 2) ? $clog2(DATA_W) : 1;

   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [SHIFT_W-1:0] shift_type;

   typedef struct packed {
      logic load;
      logic up;
      logic down;
      logic mag;
      logic store;
   } dp_cmd_type;

   typedef struct packed {
      logic rc_zero;
      logic up_ok;
      logic k_zero;
   } dp_status_type;

endpackage

// ===== rtl/core/modinv_if.sv =====
// ----------------------------------------------------------------------------
// modinv_if
// Valid/ready channels for the request and response items of the block.
// ----------------------------------------------------------------------------
interface modinv_req_if;
   import modinv_pkg::*;

   logic     valid;
   logic     ready;
   data_type value;
   data_type modulus;

   modport source (output valid, output value, output modulus, input ready);
   modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface modinv_rsp_if;
   import modinv_pkg::*;

   logic     valid;
   logic     ready;
   data_type inverse;
   logic     found;
   data_type gcd_value;

   modport source (output valid, output inverse, output found, output gcd_value,
                   input ready);
   modport sink   (input valid, input inverse, input found, input gcd_value,
                   output ready);
endinterface

// ===== rtl/core/modular_inverse_ext_euclid_top.sv =====
// one item in flight, the next one can be taken in the cycle after the previous response is stored
// each quotient bit passes through the align state and one shift-subtract step
// a finished response waits in the output register while the next item is taken
// synchronous active-high reset clears the sequencer and the response valid only
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_top
// Modular inverse and gcd by the extended Euclidean algorithm, built as a
// sequencer driving a shift-subtract datapath.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_top (
   input  logic          clock,
   input  logic          reset,
   modinv_req_if.sink    req_chan,
   modinv_rsp_if.source  rsp_chan
);
   import modinv_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   modinv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   modinv_dp u_dp (
      .clock         (clock),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_chan.value),
      .req_modulus   (req_chan.modulus),
      .rsp_inverse   (rsp_chan.inverse),
      .rsp_found     (rsp_chan.found),
      .rsp_gcd_value (rsp_chan.gcd_value)
   );

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("item taken while busy");

   a_found_gcd: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.found) |-> (rsp_chan.gcd_value == data_type'(1)))
      else $error("found set with gcd not one");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.found) |-> (rsp_chan.inverse == '0))
      else $error("inverse not zero without found");

   a_cmd_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");

endmodule

// ===== rtl/core/modinv_ctrl.sv =====
// ----------------------------------------------------------------------------
// modinv_ctrl
// Sequencer for the extended Euclid rounds: divisor alignment, shift-subtract
// steps, final reduction and hand-off to the response register.
// ----------------------------------------------------------------------------
module modinv_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  modinv_pkg::dp_status_type status,
   output modinv_pkg::dp_cmd_type    cmd
);
   import modinv_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_UP   = 5'b00010,
      S_DOWN = 5'b00100,
      S_MAG  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_UP;
            end
         end
         S_UP: begin
            if (status.rc_zero) begin
               state_in = S_MAG;
            end else if (status.up_ok) begin
               cmd.up = 1'b1;
            end else begin
               state_in = S_DOWN;
            end
         end
         S_DOWN: begin
            cmd.down = 1'b1;
            if (status.k_zero) begin
               state_in = S_UP;
            end
         end
         S_MAG: begin
            cmd.mag  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.store = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.store) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/modinv_dp.sv =====
// ----------------------------------------------------------------------------
// modinv_dp
// Remainder and coefficient registers with the shift-subtract unit that
// performs one quotient bit per cycle while shift-subtract is commanded, plus the response payload register.
// ----------------------------------------------------------------------------
module modinv_dp (
   input  logic                      clock,
   input  modinv_pkg::dp_cmd_type    cmd,
   output modinv_pkg::dp_status_type status,
   input  modinv_pkg::data_type      req_value,
   input  modinv_pkg::data_type      req_modulus,
   output modinv_pkg::data_type      rsp_inverse,
   output logic                      rsp_found,
   output modinv_pkg::data_type      rsp_gcd_value
);
   import modinv_pkg::*;

   data_type  rp_ff, rp_in;
   data_type  rc_ff, rc_in;
   data_type  sp_ff, sp_in;
   data_type  sc_ff, sc_in;
   data_type  d_ff, d_in;
   data_type  ds_ff, ds_in;
   data_type  m_ff, m_in;
   shift_type k_ff, k_in;
   logic      odd_ff, odd_in;
   data_type  inv_ff, inv_in;
   logic      found_ff, found_in;
   data_type  gcd_ff, gcd_in;

   logic      take;
   data_type  rp_sub;
   data_type  sp_add;
   logic      found_w;
   data_type  inv_w;

   // divisor copy fits once more if twice it still does not exceed the remainder
   assign status.up_ok   = ({d_ff, 1'b0} <= {1'b0, rp_ff});
   assign status.rc_zero = (rc_ff == '0);
   assign status.k_zero  = (k_ff == '0);

   assign take   = (d_ff <= rp_ff);
   assign rp_sub = take ? (rp_ff - d_ff) : rp_ff;
   assign sp_add = take ? (sp_ff + ds_ff) : sp_ff;

   assign found_w = (rp_ff == data_type'(1)) && (m_ff != '0);
   always_comb begin
      if (!found_w) begin
         inv_w = '0;
      end else if (odd_ff && (sp_ff != '0)) begin
         inv_w = m_ff - sp_ff;
      end else begin
         inv_w = sp_ff;
      end
   end

   always_comb begin
      rp_in    = rp_ff;
      rc_in    = rc_ff;
      sp_in    = sp_ff;
      sc_in    = sc_ff;
      d_in     = d_ff;
      ds_in    = ds_ff;
      m_in     = m_ff;
      k_in     = k_ff;
      odd_in   = odd_ff;
      inv_in   = inv_ff;
      found_in = found_ff;
      gcd_in   = gcd_ff;
      if (cmd.load) begin
         rp_in  = req_value;
         rc_in  = req_modulus;
         sp_in  = data_type'(1);
         sc_in  = '0;
         d_in   = req_modulus;
         ds_in  = '0;
         m_in   = req_modulus;
         k_in   = '0;
         odd_in = 1'b0;
      end
      if (cmd.up) begin
         d_in  = {d_ff[DATA_W-2:0], 1'b0};
         ds_in = {ds_ff[DATA_W-2:0], 1'b0};
         k_in  = k_ff + shift_type'(1);
      end
      if (cmd.down) begin
         if (k_ff == '0) begin
            // last quotient bit: rotate to the next round
            rp_in  = rc_ff;
            rc_in  = rp_sub;
            sp_in  = sc_ff;
            sc_in  = sp_add;
            d_in   = rp_sub;
            ds_in  = sp_add;
            odd_in = !odd_ff;
         end else begin
            rp_in = rp_sub;
            sp_in = sp_add;
            d_in  = {1'b0, d_ff[DATA_W-1:1]};
            ds_in = {1'b0, ds_ff[DATA_W-1:1]};
            k_in  = k_ff - shift_type'(1);
         end
      end
      if (cmd.mag) begin
         if (sp_ff >= m_ff) begin
            sp_in = sp_ff - m_ff;
         end
      end
      if (cmd.store) begin
         inv_in   = inv_w;
         found_in = found_w;
         gcd_in   = rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff    <= rp_in;
      rc_ff    <= rc_in;
      sp_ff    <= sp_in;
      sc_ff    <= sc_in;
      d_ff     <= d_in;
      ds_ff    <= ds_in;
      m_ff     <= m_in;
      k_ff     <= k_in;
      odd_ff   <= odd_in;
      inv_ff   <= inv_in;
      found_ff <= found_in;
      gcd_ff   <= gcd_in;
   end

   assign rsp_inverse   = inv_ff;
   assign rsp_found     = found_ff;
   assign rsp_gcd_value = gcd_ff;

endmodule
